[src/vas_pkg.sv]
`timescale 1ns / 1ps
// vas_pkg: shared types, codes and helpers for the voice allocator
// no dependencies; imported by every module of the block

package vas_pkg;

  localparam int NOTE_W    = 7;
  localparam int STAMP_W   = 32;
  localparam int FIN_W     = 4;
  localparam int GRANT_W   = 4;
  localparam int COUNT_W   = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_ALL_OFF  = 2'd2,
    OP_FINISHED = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  // one memory word per voice
  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [STAMP_W-1:0] stamp;
  } voice_rec_t;

  // packed from the lowest bit up: granted, stolen, stolen_held, released, active
  typedef struct packed {
    logic [COUNT_W-1:0] active_count;
    logic [COUNT_W-1:0] released_count;
    logic               stolen_was_held;
    logic               was_stolen;
    logic [GRANT_W-1:0] granted_voice;
  } result_t;

  function automatic logic [COUNT_W-1:0] sat_count(input int unsigned n);
    return (n > 31) ? 5'd31 : COUNT_W'(n);
  endfunction

endpackage

[src/voice_allocator_steal_oldest_core.sv]
`timescale 1ns / 1ps
// Polyphonic voice allocator with oldest-released-first stealing. Note on, note off and
// all notes off each walk the voice memory one voice per cycle through its single read
// port; a voice finished event skips the walk. One event is worked on at a time; a
// result register on the output lets the next event be taken while a result waits.
// Note numbers and start stamps live in a memory that needs no clearing after reset.
// depends on vas_pkg, vas_ctrl and vas_mem

module voice_allocator_steal_oldest_core import vas_pkg::*; #(
  parameter int VOICES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // opcode [1:0], note [8:2], finished_voice [12:9], zero fill above
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // granted_voice [3:0], was_stolen [4], stolen_was_held [5],
  // released_count [10:6], active_count [15:11]
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IW = $clog2(VOICES);

  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  voice_rec_t    rd_data, wr_data;
  logic          res_valid, res_ready;
  result_t       res;
  logic          out_valid_r;
  result_t       out_data_r;

  vas_ctrl #(
    .VOICES (VOICES),
    .IW     (IW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (op_t'(in_tdata[1:0])),
    .in_note   (in_tdata[8:2]),
    .in_fin    (in_tdata[12:9]),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  vas_mem #(
    .DEPTH (VOICES),
    .AW    (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[src/vas_mem.sv]
`timescale 1ns / 1ps
// vas_mem: note and start stamp store, one write port, one registered read port
// depends on vas_pkg for the record type

module vas_mem import vas_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  voice_rec_t    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output voice_rec_t    rd_data
);

  voice_rec_t mem [DEPTH];
  voice_rec_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/vas_ctrl.sv]
`timescale 1ns / 1ps
// vas_ctrl: event sequencer, voice marks, start counter and the per-voice scan
// depends on vas_pkg; drives the vas_mem ports

module vas_ctrl import vas_pkg::*; #(
  parameter int VOICES = 16,
  parameter int IW     = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  op_t               in_op,
  input  logic [NOTE_W-1:0] in_note,
  input  logic [FIN_W-1:0]  in_fin,
  output logic              rd_en,
  output logic [IW-1:0]     rd_addr,
  input  voice_rec_t        rd_data,
  output logic              wr_en,
  output logic [IW-1:0]     wr_addr,
  output voice_rec_t        wr_data,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  localparam int CW = $clog2(VOICES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(VOICES - 1);

  state_t              state_r, state_nxt;
  op_t                 op_r;
  logic [NOTE_W-1:0]   note_r;
  logic [FIN_W-1:0]    fin_r;
  logic [VOICES-1:0]   active_r, held_r;
  logic [CW-1:0]       act_cnt_r, rel_cnt_r;
  logic [CW-1:0]       act_cnt_nxt;
  logic [STAMP_W-1:0]  counter_r;
  logic [IW-1:0]       rd_idx_r;
  logic                cmp_vld_r;
  logic [IW-1:0]       cmp_idx_r;
  logic                idle_found_r, rel_found_r, hld_found_r;
  logic [IW-1:0]       idle_idx_r, rel_idx_r, hld_idx_r;
  logic [STAMP_W-1:0]  rel_age_r, hld_age_r;
  logic [STAMP_W-1:0]  age;
  logic                cmp_active, cmp_held, rel_hit;
  logic [IW-1:0]       grant_idx;
  logic                fin_ok;
  logic [IW-1:0]       fin_idx;
  logic                fin_kill;
  logic                commit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = (in_op == OP_FINISHED) ? S_FIN : S_SCAN;
      S_SCAN:  if (rd_idx_r == LAST_IDX) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   if (res_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      S_IDLE:  in_ready  = 1'b1;
      S_SCAN:  rd_en     = 1'b1;
      S_FIN:   res_valid = 1'b1;
      default: in_ready  = 1'b0;
    endcase
  end

  assign commit  = res_valid && res_ready;
  assign rd_addr = rd_idx_r;

  // compare stage, one voice per cycle as read data returns
  assign age        = counter_r - rd_data.stamp;
  assign cmp_active = active_r[cmp_idx_r];
  assign cmp_held   = held_r[cmp_idx_r];
  assign rel_hit    = cmp_active && cmp_held &&
                      ((op_r == OP_ALL_OFF) ||
                       ((op_r == OP_NOTE_OFF) && (rd_data.note == note_r)));

  assign grant_idx = idle_found_r ? idle_idx_r : (rel_found_r ? rel_idx_r : hld_idx_r);
  assign fin_ok    = (32'(fin_r) < VOICES);
  assign fin_idx   = IW'(fin_r);
  assign fin_kill  = fin_ok && active_r[fin_idx];

  assign wr_en         = commit && (op_r == OP_NOTE_ON);
  assign wr_addr       = grant_idx;
  assign wr_data.note  = note_r;
  assign wr_data.stamp = counter_r;

  always_comb begin
    act_cnt_nxt = act_cnt_r;
    if (op_r == OP_NOTE_ON && idle_found_r) begin
      act_cnt_nxt = act_cnt_r + CW'(1);
    end else if (op_r == OP_FINISHED && fin_kill) begin
      act_cnt_nxt = act_cnt_r - CW'(1);
    end
  end

  always_comb begin
    res = '0;
    res.active_count   = sat_count(int'(act_cnt_nxt));
    res.released_count = sat_count(int'(rel_cnt_r));
    if (op_r == OP_NOTE_ON) begin
      res.granted_voice   = GRANT_W'(grant_idx);
      res.was_stolen      = !idle_found_r;
      res.stolen_was_held = !idle_found_r && !rel_found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      active_r  <= '0;
      held_r    <= '0;
      act_cnt_r <= '0;
      counter_r <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cmp_vld_r <= (state_r == S_SCAN);
      if (commit) begin
        act_cnt_r <= act_cnt_nxt;
        if (op_r == OP_NOTE_ON) begin
          active_r[grant_idx] <= 1'b1;
          held_r[grant_idx]   <= 1'b1;
          counter_r           <= counter_r + 32'd1;
        end else if (op_r == OP_FINISHED && fin_ok) begin
          active_r[fin_idx] <= 1'b0;
          held_r[fin_idx]   <= 1'b0;
        end
      end else if (cmp_vld_r && rel_hit) begin
        held_r[cmp_idx_r] <= 1'b0;
      end
    end
  end

  // per-item datapath registers
  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx_r;
    if (in_valid && in_ready) begin
      op_r         <= in_op;
      note_r       <= in_note;
      fin_r        <= in_fin;
      rd_idx_r     <= '0;
      rel_cnt_r    <= '0;
      idle_found_r <= 1'b0;
      rel_found_r  <= 1'b0;
      hld_found_r  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_idx_r <= rd_idx_r + IW'(1);
      end
      if (cmp_vld_r) begin
        if (rel_hit) begin
          rel_cnt_r <= rel_cnt_r + CW'(1);
        end
        if (!cmp_active && !idle_found_r) begin
          idle_found_r <= 1'b1;
          idle_idx_r   <= cmp_idx_r;
        end
        // strict compare in ascending order keeps ties on the lower index
        if (!cmp_held && (!rel_found_r || age > rel_age_r)) begin
          rel_found_r <= 1'b1;
          rel_idx_r   <= cmp_idx_r;
          rel_age_r   <= age;
        end
        if (cmp_held && (!hld_found_r || age > hld_age_r)) begin
          hld_found_r <= 1'b1;
          hld_idx_r   <= cmp_idx_r;
          hld_age_r   <= age;
        end
      end
    end
  end

endmodule

[src/vas_checker.sv]
`timescale 1ns / 1ps
// vas_checker: port-level checks of the voice allocator over time
// depends on vas_pkg; bound to voice_allocator_steal_oldest_core below

module vas_checker import vas_pkg::*; #(
  parameter int VOICES = 16
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  localparam logic [COUNT_W-1:0] FULL = (VOICES > 31) ? 5'd31 : COUNT_W'(VOICES);

  // a stalled transaction keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // stealing only happens when every voice is sounding
  a_steal_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[15:11] == FULL)
    else $error("voice stolen while not all voices active");

  a_held_steal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> out_tdata[4])
    else $error("stolen_was_held without a steal");

  // a release never comes with a grant
  a_release_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10:6] != 5'd0 |-> out_tdata[3:0] == 4'd0 && !out_tdata[4])
    else $error("release result carries grant fields");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result shown right after reset");

endmodule

bind voice_allocator_steal_oldest_core vas_checker #(.VOICES(VOICES)) u_vas_checker (.*);

[test/voice_allocator_steal_oldest_core_tb.sv]
`timescale 1ns / 1ps
// testbench for voice_allocator_steal_oldest_core: directed and random note events on the
// input stream, each result checked against a behavioral allocation tracker in this file
// depends on vas_pkg and voice_allocator_steal_oldest_core

module voice_allocator_steal_oldest_core_tb;
  import vas_pkg::*;

  localparam int NUM_VOICES  = 16;
  localparam int RANDOM_EVTS = 850;
  localparam int TAIL_EVTS   = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYC  = 2 * (NUM_VOICES + 3);

  // tracks voice state and the results the block owes, in acceptance order
  class alloc_tracker;
    bit               active_q[NUM_VOICES];
    bit               held_q[NUM_VOICES];
    logic [NOTE_W-1:0] note_q[NUM_VOICES];
    logic [31:0]      stamp_q[NUM_VOICES];
    logic [31:0]      start_ctr;
    result_t          owed_results[$];
    int               errors;

    function new();
      for (int i = 0; i < NUM_VOICES; i++) begin
        active_q[i] = 0;
        held_q[i]   = 0;
        note_q[i]   = '0;
        stamp_q[i]  = '0;
      end
      start_ctr = '0;
      errors    = 0;
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    function void log_event(logic [IN_DATA_W-1:0] d);
      result_t          r;
      op_t              op;
      logic [NOTE_W-1:0] nt;
      logic [FIN_W-1:0] fv;
      int               pick;
      logic [31:0]      age;
      logic [31:0]      best;
      int unsigned      rel;
      int unsigned      cnt;
      op   = op_t'(d[1:0]);
      nt   = d[8:2];
      fv   = d[12:9];
      r    = '0;
      rel  = 0;
      cnt  = 0;
      pick = -1;
      best = '0;
      case (op)
        OP_NOTE_ON: begin
          for (int i = 0; i < NUM_VOICES; i++)
            if (!active_q[i] && pick < 0) pick = i;
          if (pick < 0) begin
            // oldest released voice first, then oldest held
            for (int i = 0; i < NUM_VOICES; i++) begin
              age = start_ctr - stamp_q[i];
              if (!held_q[i] && (pick < 0 || age > best)) begin
                pick = i;
                best = age;
              end
            end
            if (pick < 0) begin
              for (int i = 0; i < NUM_VOICES; i++) begin
                age = start_ctr - stamp_q[i];
                if (pick < 0 || age > best) begin
                  pick = i;
                  best = age;
                end
              end
            end
            r.was_stolen      = 1'b1;
            r.stolen_was_held = held_q[pick];
          end
          active_q[pick]  = 1;
          held_q[pick]    = 1;
          note_q[pick]    = nt;
          stamp_q[pick]   = start_ctr;
          start_ctr       = start_ctr + 32'd1;
          r.granted_voice = GRANT_W'(pick);
        end
        OP_NOTE_OFF: begin
          for (int i = 0; i < NUM_VOICES; i++)
            if (active_q[i] && held_q[i] && note_q[i] == nt) begin
              held_q[i] = 0;
              rel++;
            end
        end
        OP_ALL_OFF: begin
          for (int i = 0; i < NUM_VOICES; i++)
            if (active_q[i] && held_q[i]) begin
              held_q[i] = 0;
              rel++;
            end
        end
        default: begin
          if (int'(fv) < NUM_VOICES) begin
            active_q[fv] = 0;
            held_q[fv]   = 0;
          end
        end
      endcase
      for (int i = 0; i < NUM_VOICES; i++)
        if (active_q[i]) cnt++;
      r.released_count = (rel > 31) ? 5'd31 : COUNT_W'(rel);
      r.active_count   = (cnt > 31) ? 5'd31 : COUNT_W'(cnt);
      owed_results.push_back(r);
    endfunction

    function void match_result(logic [OUT_DATA_W-1:0] d);
      result_t got;
      result_t want;
      got = d;
      if (owed_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with none owed: grant=%0d stolen=%0b held=%0b rel=%0d act=%0d",
                   $realtime, got.granted_voice, got.was_stolen, got.stolen_was_held,
                   got.released_count, got.active_count);
        return;
      end
      want = owed_results.pop_front();
      if (got.granted_voice !== want.granted_voice || got.was_stolen !== want.was_stolen ||
          got.stolen_was_held !== want.stolen_was_held ||
          got.released_count !== want.released_count ||
          got.active_count !== want.active_count) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp grant=%0d stolen=%0b held=%0b rel=%0d act=%0d / got grant=%0d stolen=%0b held=%0b rel=%0d act=%0d",
                   $realtime, want.granted_voice, want.was_stolen, want.stolen_was_held,
                   want.released_count, want.active_count, got.granted_voice,
                   got.was_stolen, got.stolen_was_held, got.released_count,
                   got.active_count);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  alloc_tracker tracker;
  bit           tail_mode;
  bit           long_hold_req;
  int           stall_cycles;
  logic [NOTE_W-1:0] recent_notes[NUM_VOICES];
  int           recent_wr;

  voice_allocator_steal_oldest_core #(.VOICES(NUM_VOICES)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // both channels observed on the edge, values from before the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.log_event(in_tdata);
      if (out_tvalid && out_tready) tracker.match_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles = 0;
    else
      stall_cycles = stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request, none in the tail
  initial begin : result_sink
    int burst_left;
    int hold_left;
    burst_left = 0;
    hold_left  = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold_left     = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (tail_mode) begin
        out_tready <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(1, 10) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic send_event(op_t op, logic [NOTE_W-1:0] nt, logic [FIN_W-1:0] fv);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, fv, nt, op};
    do @(posedge clk); while (!in_tready);
    if (op == OP_NOTE_ON) begin
      recent_notes[recent_wr] = nt;
      recent_wr = (recent_wr + 1) % NUM_VOICES;
    end
  endtask

  task automatic idle_for(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  // mix 0 balanced, 1 note on heavy (held steals), 2 release heavy (released steals)
  function automatic op_t pick_op(int mix);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      1:       return (roll < 70) ? OP_NOTE_ON : (roll < 85) ? OP_NOTE_OFF :
                      (roll < 87) ? OP_ALL_OFF : OP_FINISHED;
      2:       return (roll < 50) ? OP_NOTE_ON : (roll < 90) ? OP_NOTE_OFF :
                      (roll < 93) ? OP_ALL_OFF : OP_FINISHED;
      default: return (roll < 40) ? OP_NOTE_ON : (roll < 70) ? OP_NOTE_OFF :
                      (roll < 75) ? OP_ALL_OFF : OP_FINISHED;
    endcase
  endfunction

  initial begin : stimulus
    op_t               op;
    logic [NOTE_W-1:0] nt;
    logic [FIN_W-1:0]  fv;
    tracker       = new();
    tail_mode     = 0;
    long_hold_req = 0;
    stall_cycles  = 0;
    recent_wr     = 0;
    for (int i = 0; i < NUM_VOICES; i++) recent_notes[i] = NOTE_W'($urandom_range(0, 127));
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty block, double note, repeated release, refill, both kinds of steal
    send_event(OP_FINISHED, 7'd0, 4'd0);
    send_event(OP_NOTE_OFF, 7'd60, 4'd15);
    send_event(OP_ALL_OFF, 7'd127, 4'd0);
    send_event(OP_NOTE_ON, 7'd0, 4'd15);
    send_event(OP_NOTE_ON, 7'd127, 4'd0);
    send_event(OP_NOTE_ON, 7'd64, 4'd7);
    send_event(OP_NOTE_ON, 7'd64, 4'd8);
    send_event(OP_NOTE_OFF, 7'd64, 4'd0);
    send_event(OP_NOTE_OFF, 7'd64, 4'd0);
    send_event(OP_FINISHED, 7'd0, 4'd1);
    send_event(OP_NOTE_ON, 7'd100, 4'd0);
    for (int k = 0; k < 12; k++)
      send_event(OP_NOTE_ON, NOTE_W'(10 + k * 9), FIN_W'($urandom_range(0, 15)));
    send_event(OP_NOTE_ON, 7'd33, 4'd0);
    send_event(OP_NOTE_ON, 7'd34, 4'd0);
    send_event(OP_NOTE_ON, 7'd35, 4'd0);
    send_event(OP_ALL_OFF, 7'd0, 4'd0);
    send_event(OP_FINISHED, 7'd127, 4'd15);

    for (int i = 0; i < RANDOM_EVTS; i++) begin
      if (i >= RANDOM_EVTS - TAIL_EVTS) tail_mode = 1;
      if (i == 200) long_hold_req = 1;
      if (i == 450) wait_drained();
      op = pick_op((i / 120) % 3);
      nt = NOTE_W'($urandom_range(0, 127));
      fv = FIN_W'($urandom_range(0, 15));
      // note offs mostly aim at a recently started note so they release something
      if (op == OP_NOTE_OFF && $urandom_range(0, 4) != 0)
        nt = recent_notes[$urandom_range(0, NUM_VOICES - 1)];
      else if (op == OP_NOTE_ON && $urandom_range(0, 3) == 0)
        nt = recent_notes[$urandom_range(0, NUM_VOICES - 1)];
      send_event(op, nt, fv);
      if (!tail_mode && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 10));
    end

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/vas_pkg.sv
src/vas_mem.sv
src/vas_ctrl.sv
src/voice_allocator_steal_oldest_core.sv
src/vas_checker.sv
test/voice_allocator_steal_oldest_core_tb.sv
